/* hw/rtl/lsrg_pkg.sv */
package lsrg_pkg;

	// Shuffle table depth; must be a power of two (4..64) so that the
	// bucket index is a plain top-bits slice of the last output.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Warm-up steps on reseed: table fill plus eight discarded steps.
	localparam int WARM_STEPS  = TABLE_DEPTH + 8;
	localparam int CNT_W       = $clog2(WARM_STEPS);

	localparam int VAL_W       = 31;
	localparam int MUL_W       = 15;
	localparam int PROD_W      = VAL_W + MUL_W;

	localparam logic [MUL_W-1:0] LEH_MUL = 15'd16807;
	localparam logic [VAL_W-1:0] LEH_MOD = 31'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_MAX = 31'd2147483389;

	// Request into the shared modular multiplier.
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] operand;
	} mm_req_t;

	// Result out of the shared modular multiplier.
	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] result;
	} mm_rsp_t;

endpackage

/* hw/rtl/lsrg_modmul.sv */
// x * 16807 mod (2^31 - 1): multiply into prod_s1, then Mersenne fold into res_s2.
module lsrg_modmul (
	input  logic              clk,
	input  logic              arst_n,
	input  lsrg_pkg::mm_req_t req,
	output lsrg_pkg::mm_rsp_t rsp
);

	logic                        vld_s1;
	logic [lsrg_pkg::PROD_W-1:0] prod_s1;
	logic                        vld_s2;
	logic [lsrg_pkg::VAL_W-1:0]  res_s2;

	logic [lsrg_pkg::VAL_W:0]    fold_sum;
	logic [lsrg_pkg::VAL_W:0]    fold_sub;
	logic [lsrg_pkg::VAL_W-1:0]  fold_res;

	always_comb begin
		// p = hi * 2^31 + lo == hi + lo (mod 2^31 - 1)
		fold_sum = {1'b0, prod_s1[lsrg_pkg::VAL_W-1:0]}
			+ (lsrg_pkg::VAL_W+1)'(prod_s1[lsrg_pkg::PROD_W-1:lsrg_pkg::VAL_W]);
		fold_sub = fold_sum - {1'b0, lsrg_pkg::LEH_MOD};
		if (fold_sum >= {1'b0, lsrg_pkg::LEH_MOD}) begin
			fold_res = fold_sub[lsrg_pkg::VAL_W-1:0];
		end else begin
			fold_res = fold_sum[lsrg_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_s1 <= {{lsrg_pkg::MUL_W{1'b0}}, req.operand}
				* {{lsrg_pkg::VAL_W{1'b0}}, lsrg_pkg::LEH_MUL};
		end
		if (vld_s1) begin
			res_s2 <= fold_res;
		end
	end

	assign rsp.done   = vld_s2;
	assign rsp.result = res_s2;

endmodule

/* hw/rtl/lehmer_shuffle_random_generator.sv */
// Minimal-standard Lehmer generator (x = 16807 * x mod 2^31 - 1) behind a
// Bays-Durham shuffle table of lsrg_pkg::TABLE_DEPTH entries.
// Request channel: in_valid / in_ready with action and seed. action = 0 draws
// the next deviate; action = 1 reseeds from seed (0 or 2^31 - 1 become 1),
// then draws. The first request after reset always reseeds.
// Result channel: out_valid / out_ready with deviate, one per request,
// clamped at 2147483389.
// Sequencing: one shared multiply/fold unit (prod_s1, then res_s2) does every
// generator step. A draw is one step through the unit, and a new request is
// accepted only after it has finished; a reseed first runs WARM_STEPS steps
// (TABLE_DEPTH + 8) through the unit back to back, then draws.
// The result register holds the deviate until taken; a new request is
// accepted while it waits. If a draw finishes while the previous deviate is
// still stalled, the new one parks in a holding register and in_ready stays
// low until it moves to the output.
// Reset (arst_n, async, active low) clears the sequencer, the seeded flag
// and the output valid; the table content is undefined until a reseed.
module lehmer_shuffle_random_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [lsrg_pkg::VAL_W-1:0] seed,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lsrg_pkg::VAL_W-1:0] deviate
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WARM = 4'b0010,
		ST_DRAW = 4'b0100,
		ST_PUT  = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [lsrg_pkg::VAL_W-1:0]  x_q;       // generator state
	logic [lsrg_pkg::VAL_W-1:0]  last_q;    // last shuffled value (unclamped)
	logic [lsrg_pkg::CNT_W-1:0]  cnt_q;     // warm-up step, counts down to 0
	logic                        seeded_q;
	logic                        out_vld_q;
	logic [lsrg_pkg::VAL_W-1:0]  dev_q;
	logic [lsrg_pkg::VAL_W-1:0]  pend_q;    // parked result while output stalls

	// shuffle table, undefined until the first reseed fills it
	logic [lsrg_pkg::VAL_W-1:0]  tbl_mem [lsrg_pkg::TABLE_DEPTH];
	logic [lsrg_pkg::VAL_W-1:0]  rd_q;

	lsrg_pkg::mm_req_t           mm_req;
	lsrg_pkg::mm_rsp_t           mm_rsp;

	logic                        need_reseed;
	logic [lsrg_pkg::VAL_W-1:0]  seed_clean;
	logic [lsrg_pkg::IDX_W-1:0]  idx;
	logic                        wr_en;
	logic [lsrg_pkg::IDX_W-1:0]  wr_addr;
	logic                        out_free;
	logic                        out_load;
	logic [lsrg_pkg::VAL_W-1:0]  sat_val;
	logic                        accept;

	lsrg_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign need_reseed = action || !seeded_q;
	assign out_free    = !out_vld_q || out_ready;

	// a finished draw (direct or parked) moves into the output register
	assign out_load = ((state_q == ST_DRAW) && mm_rsp.done && out_free)
		|| ((state_q == ST_PUT) && out_free);

	// NDIV is 2^31 / TABLE_DEPTH, so the bucket is the top index bits
	assign idx = last_q[lsrg_pkg::VAL_W-1 -: lsrg_pkg::IDX_W];

	always_comb begin
		if (seed == '0 || seed == lsrg_pkg::LEH_MOD) begin
			seed_clean = lsrg_pkg::VAL_W'(1);
		end else begin
			seed_clean = seed;
		end
	end

	// clamp applies to the delivered value only
	assign sat_val = (rd_q > lsrg_pkg::SAT_MAX) ? lsrg_pkg::SAT_MAX : rd_q;

	// Multiplier issue: on accept, and back to back through warm-up.
	// The last warm-up result feeds straight into the draw step.
	always_comb begin
		mm_req.start   = 1'b0;
		mm_req.operand = x_q;
		case (state_q)
			ST_IDLE: begin
				mm_req.start   = in_valid;
				mm_req.operand = need_reseed ? seed_clean : x_q;
			end
			ST_WARM: begin
				mm_req.start   = mm_rsp.done;
				mm_req.operand = mm_rsp.result;
			end
			default: begin
				mm_req.start   = 1'b0;
				mm_req.operand = x_q;
			end
		endcase
	end

	// Single table write port: warm-up fill or draw replacement
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx;
		case (state_q)
			ST_WARM: begin
				wr_en   = mm_rsp.done
					&& (cnt_q < lsrg_pkg::CNT_W'(lsrg_pkg::TABLE_DEPTH));
				wr_addr = cnt_q[lsrg_pkg::IDX_W-1:0];
			end
			ST_DRAW: begin
				wr_en   = mm_rsp.done;
				wr_addr = idx;
			end
			default: begin
				wr_en   = 1'b0;
				wr_addr = idx;
			end
		endcase
	end

	// Read of the selected bucket; last_q is set by the time the draw step is
	// issued, so rd_q is valid when mm_rsp.done rises.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= mm_rsp.result;
		end
		rd_q <= tbl_mem[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			seeded_q  <= 1'b0;
			out_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (need_reseed) begin
							cnt_q   <= lsrg_pkg::CNT_W'(lsrg_pkg::WARM_STEPS - 1);
							state_q <= ST_WARM;
						end else begin
							state_q <= ST_DRAW;
						end
					end
				end
				ST_WARM: begin
					if (mm_rsp.done) begin
						if (cnt_q == '0) begin
							seeded_q <= 1'b1;
							state_q  <= ST_DRAW;
						end else begin
							cnt_q <= cnt_q - lsrg_pkg::CNT_W'(1);
						end
					end
				end
				ST_DRAW: begin
					if (mm_rsp.done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PUT;
						end
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_WARM: begin
				if (mm_rsp.done && cnt_q == '0) begin
					// table entry 0 was just written with this value
					last_q <= mm_rsp.result;
				end
			end
			ST_DRAW: begin
				if (mm_rsp.done) begin
					x_q    <= mm_rsp.result;
					last_q <= rd_q;
					pend_q <= sat_val;
					if (out_free) begin
						dev_q <= sat_val;
					end
				end
			end
			ST_PUT: begin
				if (out_free) begin
					dev_q <= pend_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_vld_q;
	assign deviate   = dev_q;

endmodule

/* hw/rtl/lsrg_checker.sv */
module lsrg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       action,
	input logic [lsrg_pkg::VAL_W-1:0] seed,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lsrg_pkg::VAL_W-1:0] deviate
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(deviate))
		else $error("deviate changed or dropped while stalled");

	// deviate stays in the clamped range
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> deviate != '0 && deviate <= lsrg_pkg::SAT_MAX)
		else $error("deviate out of range");

	// every accepted request drops in_ready while the unit works on it
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request accepted while the unit is busy");

	// a reseed is still busy at the checked delay after its acceptance
	a_reseed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && action |-> ##8 !in_ready)
		else $error("reseed finished too early");

endmodule

bind lehmer_shuffle_random_generator lsrg_checker u_lsrg_checker (.*);
